### design/wrld_pkg.sv
package wrld_pkg;

	// Field and register widths
	localparam int SAMPLE_W    = 12;
	localparam int WIN_W       = 11;
	localparam int CFG_W       = 12;
	localparam int CFG_INDEX_W = 2;
	localparam int LEVEL_W     = 2;

	// Longest window; the remainder of a division by the window stays below it
	localparam int MAX_WINDOW = 1024;
	localparam int REM_W      = $clog2(MAX_WINDOW);

	// Squares, running sum and root
	localparam int SQUARE_W = 2 * SAMPLE_W;
	localparam int SUM_W    = 34;
	localparam int ROOT_W   = SUM_W / 2;

	// Reset values of the registers
	localparam logic [WIN_W-1:0]    WINDOW_RESET = WIN_W'(200);
	localparam logic [SAMPLE_W-1:0] OFFSET_RESET = SAMPLE_W'(2048);
	localparam logic [SAMPLE_W-1:0] QUIET_RESET  = SAMPLE_W'(124);
	localparam logic [SAMPLE_W-1:0] LOUD_RESET   = SAMPLE_W'(621);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WINDOW_LENGTH   = 2'd0,
		REG_MIDSCALE_OFFSET = 2'd1,
		REG_QUIET_LIMIT     = 2'd2,
		REG_LOUD_LIMIT      = 2'd3
	} cfg_reg_t;

	typedef enum logic [LEVEL_W-1:0] {
		LEVEL_QUIET    = 2'd0,
		LEVEL_MODERATE = 2'd1,
		LEVEL_LOUD     = 2'd2
	} level_t;

	// Request carrying a 34-bit sum or quotient between stages
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] value;
	} sum_req_t;

	// Request carrying the integer root to the output register
	typedef struct packed {
		logic              valid;
		logic [ROOT_W-1:0] root;
	} root_req_t;

	// Zero counts as one; anything above the longest window saturates
	function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
		logic [WIN_W-1:0] r;
		if (w == '0) begin
			r = WIN_W'(1);
		end else if (w > WIN_W'(MAX_WINDOW)) begin
			r = WIN_W'(MAX_WINDOW);
		end else begin
			r = w;
		end
		return r;
	endfunction

endpackage

### design/wrld_if.sv
interface wrld_sample_if;
	logic                          valid;
	logic                          ready;
	logic [wrld_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface wrld_result_if;
	logic                          valid;
	logic                          ready;
	logic [wrld_pkg::SAMPLE_W-1:0] rms_code;
	logic [wrld_pkg::LEVEL_W-1:0]  level;

	modport source (output valid, output rms_code, output level, input ready);
	modport sink (input valid, input rms_code, input level, output ready);
endinterface

### design/wrld_acc.sv
module wrld_acc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [wrld_pkg::SAMPLE_W-1:0] sample,
	input  logic [wrld_pkg::SAMPLE_W-1:0] midscale_offset,
	input  logic [wrld_pkg::WIN_W-1:0]    window_eff,
	output wrld_pkg::sum_req_t            sum_req,
	input  logic                          sum_ready
);

	localparam int STEP_W = $clog2(wrld_pkg::SAMPLE_W);

	typedef enum logic [1:0] {
		ACC_IDLE,
		ACC_SQUARE,
		ACC_CLOSE,
		ACC_HAND
	} acc_state_t;

	acc_state_t                    state_q;
	logic [wrld_pkg::SQUARE_W-1:0] md_q;
	logic [wrld_pkg::SAMPLE_W-1:0] mr_q;
	logic [STEP_W-1:0]             step_q;
	logic [wrld_pkg::SUM_W-1:0]    sum_q;
	logic [wrld_pkg::WIN_W-1:0]    count_q;

	logic [wrld_pkg::SAMPLE_W-1:0] mag;
	logic [wrld_pkg::WIN_W-1:0]    count_next;

	assign mag = (sample >= midscale_offset) ? (sample - midscale_offset)
	                                         : (midscale_offset - sample);
	assign count_next = count_q + wrld_pkg::WIN_W'(1);

	assign in_ready      = (state_q == ACC_IDLE);
	assign sum_req.valid = (state_q == ACC_HAND);
	assign sum_req.value = sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ACC_IDLE;
			md_q    <= '0;
			mr_q    <= '0;
			step_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ACC_IDLE: begin
					if (in_valid) begin
						md_q    <= wrld_pkg::SQUARE_W'(mag);
						mr_q    <= mag;
						step_q  <= '0;
						state_q <= ACC_SQUARE;
					end
				end
				ACC_SQUARE: begin
					// shift-add: one multiplier bit per cycle straight into the sum
					if (mr_q[0]) begin
						sum_q <= sum_q + wrld_pkg::SUM_W'(md_q);
					end
					md_q   <= {md_q[wrld_pkg::SQUARE_W-2:0], 1'b0};
					mr_q   <= {1'b0, mr_q[wrld_pkg::SAMPLE_W-1:1]};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(wrld_pkg::SAMPLE_W - 1)) begin
						state_q <= ACC_CLOSE;
					end
				end
				ACC_CLOSE: begin
					if (count_next >= window_eff) begin
						state_q <= ACC_HAND;
					end else begin
						count_q <= count_next;
						state_q <= ACC_IDLE;
					end
				end
				ACC_HAND: begin
					if (sum_ready) begin
						sum_q   <= '0;
						count_q <= '0;
						state_q <= ACC_IDLE;
					end
				end
				default: begin
					state_q <= ACC_IDLE;
				end
			endcase
		end
	end

	// A window always closes before the count reaches the longest window
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < wrld_pkg::WIN_W'(wrld_pkg::MAX_WINDOW))
		else $error("sample count reached the longest window without closing");

endmodule

### design/wrld_div.sv
module wrld_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wrld_pkg::sum_req_t         dividend_req,
	output logic                       dividend_ready,
	input  logic [wrld_pkg::WIN_W-1:0] divisor,
	output wrld_pkg::sum_req_t         quot_req,
	input  logic                       quot_ready
);

	localparam int STEP_W = $clog2(wrld_pkg::SUM_W);

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	div_state_t                 state_q;
	logic [wrld_pkg::SUM_W-1:0] q_q;
	logic [wrld_pkg::REM_W-1:0] rem_q;
	logic [wrld_pkg::WIN_W-1:0] div_q;
	logic [STEP_W-1:0]          step_q;

	logic [wrld_pkg::WIN_W-1:0] trial;
	logic [wrld_pkg::WIN_W-1:0] diff;
	logic                       ge;

	// restoring division, one quotient bit per cycle
	assign trial = wrld_pkg::WIN_W'({rem_q, q_q[wrld_pkg::SUM_W-1]});
	assign ge    = (trial >= div_q);
	assign diff  = trial - div_q;

	assign dividend_ready = (state_q == DIV_IDLE);
	assign quot_req.valid = (state_q == DIV_DONE);
	assign quot_req.value = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			q_q     <= '0;
			rem_q   <= '0;
			div_q   <= wrld_pkg::WIN_W'(1);
			step_q  <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (dividend_req.valid) begin
						q_q     <= dividend_req.value;
						rem_q   <= '0;
						div_q   <= divisor;
						step_q  <= '0;
						state_q <= DIV_RUN;
					end
				end
				DIV_RUN: begin
					q_q    <= {q_q[wrld_pkg::SUM_W-2:0], ge};
					rem_q  <= ge ? diff[wrld_pkg::REM_W-1:0] : trial[wrld_pkg::REM_W-1:0];
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(wrld_pkg::SUM_W - 1)) begin
						state_q <= DIV_DONE;
					end
				end
				DIV_DONE: begin
					if (quot_ready) begin
						state_q <= DIV_IDLE;
					end
				end
				default: begin
					state_q <= DIV_IDLE;
				end
			endcase
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == DIV_RUN) |-> (div_q != '0) && (wrld_pkg::WIN_W'(rem_q) < div_q))
		else $error("partial remainder not below a non-zero divisor");

endmodule

### design/wrld_sqrt.sv
module wrld_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  wrld_pkg::sum_req_t  rad_req,
	output logic                rad_ready,
	output wrld_pkg::root_req_t root_req,
	input  logic                root_ready
);

	localparam int STEP_W  = $clog2(wrld_pkg::ROOT_W);
	localparam int REM_W   = wrld_pkg::ROOT_W + 1;
	localparam int SHIFT_W = REM_W + 2;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_RUN,
		SQ_DONE
	} sq_state_t;

	sq_state_t                   state_q;
	logic [wrld_pkg::SUM_W-1:0]  rad_q;
	logic [REM_W-1:0]            rem_q;
	logic [wrld_pkg::ROOT_W-1:0] root_q;
	logic [STEP_W-1:0]           step_q;

	logic [SHIFT_W-1:0] shifted;
	logic [SHIFT_W-1:0] trial;
	logic [SHIFT_W-1:0] diff;
	logic               ge;

	// digit-by-digit root: two radicand bits in, one root bit out per cycle
	assign shifted = {rem_q, rad_q[wrld_pkg::SUM_W-1 -: 2]};
	assign trial   = SHIFT_W'({root_q, 2'b01});
	assign ge      = (shifted >= trial);
	assign diff    = shifted - trial;

	assign rad_ready     = (state_q == SQ_IDLE);
	assign root_req.valid = (state_q == SQ_DONE);
	assign root_req.root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			rad_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				SQ_IDLE: begin
					if (rad_req.valid) begin
						rad_q   <= rad_req.value;
						rem_q   <= '0;
						root_q  <= '0;
						step_q  <= '0;
						state_q <= SQ_RUN;
					end
				end
				SQ_RUN: begin
					rad_q  <= {rad_q[wrld_pkg::SUM_W-3:0], 2'b00};
					rem_q  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
					root_q <= {root_q[wrld_pkg::ROOT_W-2:0], ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(wrld_pkg::ROOT_W - 1)) begin
						state_q <= SQ_DONE;
					end
				end
				SQ_DONE: begin
					if (root_ready) begin
						state_q <= SQ_IDLE;
					end
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	// the remainder never exceeds twice the partial root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_RUN) |-> (rem_q <= {root_q, 1'b0}))
		else $error("root remainder exceeds twice the partial root");

endmodule

### design/windowed_rms_level_detector.sv
// Windowed RMS level detector.
// samples (sink): one 12-bit ADC code per request. Each is centred on
// midscale_offset, squared by a bit-serial shift-add unit and added to a
// running sum. results (source): one request per closed window carrying
// rms_code = floor(sqrt(floor(sum / window))) and a level of quiet,
// moderate or loud against quiet_limit and loud_limit.
// Configuration: cfg_wen, cfg_index, cfg_data write one register per edge;
// write only while the block is idle.
// Flow: a sample that does not close a window holds the input while it is
// loaded, squared in the squaring unit and counted. A closing sample goes
// on through a radix-2 divider and a digit-serial square root before a
// valid result appears. The squarer is free again after handing over the
// sum, so later samples overlap the division; with window_length 1 the
// divider sets the pace.
// Reset clears the sum and count and loads the register defaults (window
// 200, offset 2048, limits 124 and 621). A stalled receiver holds the result
// in the output register; the next result then waits in the root unit, and
// the sample input stalls once the divider and squarer behind it are full.
module windowed_rms_level_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [wrld_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wrld_pkg::CFG_W-1:0]       cfg_data,
	wrld_sample_if.sink                      samples,
	wrld_result_if.source                    results
);

	// Configuration registers
	logic [wrld_pkg::WIN_W-1:0]    window_length_q;
	logic [wrld_pkg::SAMPLE_W-1:0] midscale_offset_q;
	logic [wrld_pkg::SAMPLE_W-1:0] quiet_limit_q;
	logic [wrld_pkg::SAMPLE_W-1:0] loud_limit_q;

	// Output register
	logic                          out_valid_q;
	logic [wrld_pkg::SAMPLE_W-1:0] rms_q;
	wrld_pkg::level_t              level_q;

	// Stage requests
	wrld_pkg::sum_req_t  sum_req;
	logic                sum_ready;
	wrld_pkg::sum_req_t  quot_req;
	logic                quot_ready;
	wrld_pkg::root_req_t root_req;
	logic                root_ready;

	logic [wrld_pkg::WIN_W-1:0] window_eff;
	wrld_pkg::level_t           level_next;
	logic                       acc_ready;

	assign window_eff = wrld_pkg::eff_window(window_length_q);

	// Hold config registers; a write lands on the addressed one only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q   <= wrld_pkg::WINDOW_RESET;
			midscale_offset_q <= wrld_pkg::OFFSET_RESET;
			quiet_limit_q     <= wrld_pkg::QUIET_RESET;
			loud_limit_q      <= wrld_pkg::LOUD_RESET;
		end else if (cfg_wen) begin
			case (wrld_pkg::cfg_reg_t'(cfg_index))
				wrld_pkg::REG_WINDOW_LENGTH: begin
					window_length_q <= cfg_data[wrld_pkg::WIN_W-1:0];
				end
				wrld_pkg::REG_MIDSCALE_OFFSET: begin
					midscale_offset_q <= cfg_data[wrld_pkg::SAMPLE_W-1:0];
				end
				wrld_pkg::REG_QUIET_LIMIT: begin
					quiet_limit_q <= cfg_data[wrld_pkg::SAMPLE_W-1:0];
				end
				wrld_pkg::REG_LOUD_LIMIT: begin
					loud_limit_q <= cfg_data[wrld_pkg::SAMPLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Square and accumulate, then close the window
	wrld_acc u_acc (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (samples.valid),
		.in_ready        (acc_ready),
		.sample          (samples.sample),
		.midscale_offset (midscale_offset_q),
		.window_eff      (window_eff),
		.sum_req         (sum_req),
		.sum_ready       (sum_ready)
	);

	assign samples.ready = acc_ready;

	// Divide the closed sum by the effective window
	wrld_div u_div (
		.clk            (clk),
		.arst_n         (arst_n),
		.dividend_req   (sum_req),
		.dividend_ready (sum_ready),
		.divisor        (window_eff),
		.quot_req       (quot_req),
		.quot_ready     (quot_ready)
	);

	// Integer square root of the mean square
	wrld_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.rad_req    (quot_req),
		.rad_ready  (quot_ready),
		.root_req   (root_req),
		.root_ready (root_ready)
	);

	// Classify on the full root; crossed limits fall through to loud
	always_comb begin
		if (root_req.root < wrld_pkg::ROOT_W'(quiet_limit_q)) begin
			level_next = wrld_pkg::LEVEL_QUIET;
		end else if (root_req.root < wrld_pkg::ROOT_W'(loud_limit_q)) begin
			level_next = wrld_pkg::LEVEL_MODERATE;
		end else begin
			level_next = wrld_pkg::LEVEL_LOUD;
		end
	end

	// Take a new root whenever the output register is empty or being drained
	assign root_ready = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rms_q       <= '0;
			level_q     <= wrld_pkg::LEVEL_QUIET;
		end else begin
			if (root_req.valid && root_ready) begin
				out_valid_q <= 1'b1;
				rms_q       <= root_req.root[wrld_pkg::SAMPLE_W-1:0];
				level_q     <= level_next;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid    = out_valid_q;
	assign results.rms_code = rms_q;
	assign results.level    = level_q;

endmodule
